// ----- rtl/mpvt_pkg.sv -----
// Package for the pose and velocity tracker: item structs, controller states,
// command and status groups, and shared constants. No dependencies.
package mpvt_pkg;

  localparam int          MAX_BODIES_DEF = 16;
  localparam logic [29:0] NS_PER_S       = 30'd1000000000;
  localparam logic [63:0] LEAST_INIT     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
  localparam logic [63:0] SQRT_BIT_INIT  = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [3:0]         body_index;
    logic               tracking_ok;
    logic [63:0]        send_time;
    logic [63:0]        arrive_time;
    logic [63:0]        exposure_time;
    logic signed [31:0] pos_north;
    logic signed [31:0] pos_up;
    logic signed [31:0] pos_east_in;
    logic signed [31:0] quat_in_x;
    logic signed [31:0] quat_in_y;
    logic signed [31:0] quat_in_z;
    logic signed [31:0] quat_in_w;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        stamp_ns;
    logic signed [31:0] east_pos;
    logic signed [31:0] north_pos;
    logic signed [31:0] up_pos;
    logic signed [31:0] quat_out_x;
    logic signed [31:0] quat_out_y;
    logic signed [31:0] quat_out_z;
    logic signed [31:0] quat_out_w;
    logic signed [31:0] vel_east;
    logic signed [31:0] vel_north;
    logic signed [31:0] vel_up;
    logic               vel_valid;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_NORM, S_SQ, S_SQRT, S_QDIV, S_QWAIT,
    S_VMUL, S_VDIV, S_VWAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic norm_step;
    logic sq_step;
    logic sqrt_step;
    logic qdiv_start;
    logic qdiv_store;
    logic cnt_clr;
    logic vmul;
    logic vdiv_start;
    logic vdiv_store;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic zero_quat;
    logic norm_done;
    logic sq_last;
    logic sqrt_last;
    logic q_last;
    logic axis_last;
    logic vel_ok;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/mpvt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mpvt_div.sv -----
// Iterative 64-bit unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
module mpvt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo,
  output logic [63:0] rem,
  output logic        done
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] dvs;
  logic [64:0] sh;
  logic [64:0] diff;
  logic        qbit;

  always_comb begin
    sh   = {rem, quo[63]};
    diff = sh - {1'b0, dvs};
    qbit = (sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      quo <= {quo[62:0], qbit};
      rem <= qbit ? diff[63:0] : sh[63:0];
    end
  end

endmodule

// ----- rtl/mpvt_datapath.sv -----
// Datapath of the tracker: input and output registers, offset tracking,
// quaternion scaling, squares, root, divisions and history memory.
// Depends on mpvt_pkg, mpvt_div and mpvt_ram.
module mpvt_datapath import mpvt_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

  in_item_t           item;
  logic [63:0]        least;
  logic [63:0]        stamp;
  logic [31:0]        a [4];
  logic [3:0]         sgn;
  logic [63:0]        s;
  logic [63:0]        prod;
  logic [63:0]        a3sq;
  logic [63:0]        sq_rem;
  logic [63:0]        r;
  logic [63:0]        sbit;
  logic [2:0]         cnt;
  logic [31:0]        qres [4];
  logic [31:0]        vel [3];
  logic               vneg;
  logic [MAX_BODIES-1:0] seen;

  logic [63:0]  off;
  logic [63:0]  least_new;
  logic [31:0]  aor;
  logic [AW-1:0] slot;
  logic          in_range;
  logic          seen_bit;
  logic [159:0]  rdata;
  logic [63:0]   dt;
  logic [32:0]   mul_a;
  logic [32:0]   mul_b;
  logic [65:0]   mul_p;
  logic signed [32:0] cur;
  logic signed [32:0] prv;
  logic signed [32:0] d;
  logic [32:0]   mag;
  logic [64:0]   sq_t;
  logic [63:0]   qnum;
  logic [63:0]   div_num;
  logic [63:0]   div_den;
  logic [63:0]   quo;
  logic [63:0]   rem;
  logic          div_done;
  logic          flip;
  logic [1:0]    sel;
  logic          qneg;
  logic [63:0]   vq;
  logic [31:0]   vsat;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (32'd0 - v) : v;
  endfunction

  always_comb begin
    off       = item.send_time - item.arrive_time;
    least_new = ($signed(off) < $signed(least)) ? off : least;
    aor       = a[0] | a[1] | a[2] | a[3];
    slot      = AW'(item.body_index);
    in_range  = ({28'd0, item.body_index} < 32'(MAX_BODIES));
    seen_bit  = in_range && seen[slot];
    dt        = stamp - rdata[159:96];
    unique case (cnt[1:0])
      2'd0: begin
        cur = 33'(item.pos_east_in);
        prv = 33'($signed(rdata[95:64]));
      end
      2'd1: begin
        cur = 33'(item.pos_north);
        prv = 33'($signed(rdata[63:32]));
      end
      default: begin
        cur = 33'(item.pos_up);
        prv = 33'($signed(rdata[31:0]));
      end
    endcase
    d     = cur - prv;
    mag   = d[32] ? (33'd0 - d) : d;
    mul_a = cmd.vmul ? mag : {1'b0, a[cnt[1:0]]};
    mul_b = cmd.vmul ? {3'd0, NS_PER_S} : {1'b0, a[cnt[1:0]]};
    mul_p = mul_a * mul_b;
    sq_t  = {1'b0, r} + {1'b0, sbit};
    qnum  = ({32'd0, a[cnt[1:0]]} << 30) + (r >> 1);
    div_num = cmd.qdiv_start ? qnum : prod;
    div_den = cmd.qdiv_start ? r : dt;
    sel = 2'd0;
    if (a[1] > a[0]) begin
      sel = 2'd1;
    end
    if (a[2] > a[sel]) begin
      sel = 2'd2;
    end
    flip = ({a3sq, 2'b00} > {2'b00, s}) ? sgn[3] : sgn[sel];
    qneg = sgn[cnt[1:0]] ^ flip;
    vq   = quo + {63'd0, (rem >= (dt - rem))};
    if (vneg) begin
      vsat = (vq[63:31] != '0) ? 32'h8000_0000 : (32'd0 - vq[31:0]);
    end else begin
      vsat = (vq[63:31] != '0) ? 32'h7FFF_FFFF : vq[31:0];
    end
  end

  always_comb begin
    stat.zero_quat = (aor == '0);
    stat.norm_done = (aor[31:30] == 2'b01);
    stat.sq_last   = (cnt == 3'd4);
    stat.sqrt_last = sbit[0];
    stat.q_last    = (cnt == 3'd3);
    stat.axis_last = (cnt == 3'd2);
    stat.vel_ok    = seen_bit && (dt != '0) && !dt[63];
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least     <= LEAST_INIT;
      seen      <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.prep) begin
        least <= least_new;
      end
      if (cmd.finish && in_range) begin
        seen[slot] <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.prep || cmd.sqrt_step || cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.sq_step || cmd.qdiv_store || cmd.vdiv_store) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
    if (cmd.prep) begin
      stamp <= item.exposure_time - least_new;
      a[0]  <= abs32(item.quat_in_z);
      a[1]  <= abs32(item.quat_in_x);
      a[2]  <= abs32(item.quat_in_y);
      a[3]  <= abs32(item.quat_in_w);
      sgn   <= {item.quat_in_w[31], item.quat_in_y[31], item.quat_in_x[31],
                item.quat_in_z[31]};
      for (int i = 0; i < 3; i++) begin
        vel[i] <= '0;
      end
    end
    if (cmd.norm_step) begin
      for (int i = 0; i < 4; i++) begin
        a[i] <= aor[31] ? (a[i] >> 1) : (a[i] << 1);
      end
    end
    if (cmd.sq_step) begin
      prod <= mul_p[63:0];
      s    <= (cnt == 3'd0) ? 64'd0 : (s + prod);
      if (cnt == 3'd4) begin
        a3sq   <= prod;
        sq_rem <= s + prod;
        r      <= '0;
        sbit   <= SQRT_BIT_INIT;
      end
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, sq_rem} >= sq_t) begin
        sq_rem <= sq_rem - sq_t[63:0];
        r      <= (r >> 1) + sbit;
      end else begin
        r <= r >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.qdiv_store) begin
      qres[cnt[1:0]] <= qneg ? (32'd0 - quo[31:0]) : quo[31:0];
    end
    if (cmd.vmul) begin
      prod <= mul_p[63:0];
      vneg <= d[32];
    end
    if (cmd.vdiv_store) begin
      vel[cnt[1:0]] <= vsat;
    end
    if (cmd.finish) begin
      out_item.stamp_ns   <= stamp;
      out_item.east_pos   <= item.pos_east_in;
      out_item.north_pos  <= item.pos_north;
      out_item.up_pos     <= item.pos_up;
      out_item.quat_out_x <= stat.zero_quat ? 32'd0 : qres[0];
      out_item.quat_out_y <= stat.zero_quat ? 32'd0 : qres[1];
      out_item.quat_out_z <= stat.zero_quat ? 32'd0 : qres[2];
      out_item.quat_out_w <= stat.zero_quat ? ONE_Q30 : qres[3];
      out_item.vel_east   <= vel[0];
      out_item.vel_north  <= vel[1];
      out_item.vel_up     <= vel[2];
      out_item.vel_valid  <= stat.vel_ok;
    end
  end

  mpvt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.qdiv_start || cmd.vdiv_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .rem   (rem),
    .done  (div_done)
  );

  mpvt_ram #(
    .WIDTH (160),
    .DEPTH (MAX_BODIES)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.finish && in_range),
    .waddr (slot),
    .wdata ({stamp, item.pos_east_in, item.pos_north, item.pos_up}),
    .re    (cmd.prep),
    .raddr (slot),
    .rdata (rdata)
  );

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result register not loaded after finish");

  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    cmd.qdiv_store |-> (quo[63:31] == '0))
    else $error("normalized component out of range");

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.qdiv_start |-> (r != '0))
    else $error("division by a zero root");

endmodule

// ----- rtl/mpvt_ctrl.sv -----
// Controller state machine of the tracker: sequences the datapath phases.
// Depends on mpvt_pkg.
module mpvt_ctrl import mpvt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  tracking_ok,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid && tracking_ok) state_next = S_PREP;
      S_PREP:  state_next = S_NORM;
      S_NORM: begin
        if (stat.zero_quat) begin
          state_next = stat.vel_ok ? S_VMUL : S_DONE;
        end else if (stat.norm_done) begin
          state_next = S_SQ;
        end
      end
      S_SQ:    if (stat.sq_last) state_next = S_SQRT;
      S_SQRT:  if (stat.sqrt_last) state_next = S_QDIV;
      S_QDIV:  state_next = S_QWAIT;
      S_QWAIT: begin
        if (stat.div_done) begin
          if (stat.q_last) begin
            state_next = stat.vel_ok ? S_VMUL : S_DONE;
          end else begin
            state_next = S_QDIV;
          end
        end
      end
      S_VMUL:  state_next = S_VDIV;
      S_VDIV:  state_next = S_VWAIT;
      S_VWAIT: begin
        if (stat.div_done) begin
          state_next = stat.axis_last ? S_DONE : S_VMUL;
        end
      end
      S_DONE:  if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_PREP:  cmd.prep = 1'b1;
      S_NORM: begin
        cmd.norm_step = !stat.zero_quat && !stat.norm_done;
        cmd.cnt_clr   = stat.zero_quat;
      end
      S_SQ:    cmd.sq_step = 1'b1;
      S_SQRT:  cmd.sqrt_step = 1'b1;
      S_QDIV:  cmd.qdiv_start = 1'b1;
      S_QWAIT: begin
        cmd.qdiv_store = stat.div_done;
        cmd.cnt_clr    = stat.div_done && stat.q_last;
      end
      S_VMUL:  cmd.vmul = 1'b1;
      S_VDIV:  cmd.vdiv_start = 1'b1;
      S_VWAIT: cmd.vdiv_store = stat.div_done;
      S_DONE:  cmd.finish = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/mocap_pose_velocity_tracker.sv -----
// Top level of the motion-capture pose and velocity tracker.
// Depends on mpvt_pkg, mpvt_ctrl and mpvt_datapath.
//
// The block takes one rigid-body sample per item and gives one result item for
// each sample whose tracking flag is set; other samples are dropped at once.
// One sample is worked on at a time. The quaternion is scaled by n (0 to 30)
// one-bit shifts; the four quaternion divisions and the three velocity
// divisions run on one shared divider. When the velocity is not formed the
// three velocity divisions are skipped. A finished result waits in an output
// register while the next sample is accepted. History is kept in a small
// memory of MAX_BODIES entries, with a seen flag per entry.
module mocap_pose_velocity_tracker import mpvt_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  cmd_t  cmd;
  stat_t stat;

  mpvt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .tracking_ok (in_item.tracking_ok),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  mpvt_datapath #(
    .MAX_BODIES (MAX_BODIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
